[src/sdr_pkg.sv]
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants for the salsa20 doubleround pipeline: word and
// state types, quarterround word orderings and rotate amounts.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned NUM_WORDS = 16;
   localparam int unsigned QR_WORDS  = 4;
   localparam int unsigned QR_LANES  = 4;
   localparam int unsigned NUM_ROUNDS = 2;
   localparam int unsigned NUM_STAGES = NUM_ROUNDS * QR_WORDS;

   typedef logic [WORD_W-1:0]                 word_type;
   typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  state_type;
   typedef logic [$clog2(NUM_WORDS)-1:0]      word_idx_type;

   // word indices per round, lane and quarterround position
   localparam word_idx_type QR_ORDER [NUM_ROUNDS][QR_LANES][QR_WORDS] = '{
      '{ '{4'd0,  4'd4,  4'd8,  4'd12},
         '{4'd5,  4'd9,  4'd13, 4'd1 },
         '{4'd10, 4'd14, 4'd2,  4'd6 },
         '{4'd15, 4'd3,  4'd7,  4'd11} },
      '{ '{4'd0,  4'd1,  4'd2,  4'd3 },
         '{4'd5,  4'd6,  4'd7,  4'd4 },
         '{4'd10, 4'd11, 4'd8,  4'd9 },
         '{4'd15, 4'd12, 4'd13, 4'd14} }
   };

   localparam int unsigned QR_ROT [QR_WORDS] = '{7, 9, 13, 18};

endpackage

`default_nettype wire

[src/salsa_doubleround.sv]
// ----------------------------------------------------------------------------
// salsa_doubleround
// Salsa20 doubleround: columnround then rowround on a 16-word state.
// Pipeline: one registered stage per add-rotate-xor step of the quarterround,
// four lanes side by side.
// Throughput: one transaction per cycle while rsp_stall is low; stages with
// bubbles keep accepting while a finished result waits on rsp_stall.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa_doubleround (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_state_pair_0,
   input  wire  [63:0] req_state_pair_1,
   input  wire  [63:0] req_state_pair_2,
   input  wire  [63:0] req_state_pair_3,
   input  wire  [63:0] req_state_pair_4,
   input  wire  [63:0] req_state_pair_5,
   input  wire  [63:0] req_state_pair_6,
   input  wire  [63:0] req_state_pair_7,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_mixed_pair_0,
   output logic [63:0] rsp_mixed_pair_1,
   output logic [63:0] rsp_mixed_pair_2,
   output logic [63:0] rsp_mixed_pair_3,
   output logic [63:0] rsp_mixed_pair_4,
   output logic [63:0] rsp_mixed_pair_5,
   output logic [63:0] rsp_mixed_pair_6,
   output logic [63:0] rsp_mixed_pair_7
);
   import sdr_pkg::*;

   state_type             stage_state [NUM_STAGES+1];
   logic [NUM_STAGES:0]   stage_valid;
   logic [NUM_STAGES:0]   stage_ready;
   state_type             res_state;

   assign stage_state[0] = {req_state_pair_7, req_state_pair_6, req_state_pair_5,
                            req_state_pair_4, req_state_pair_3, req_state_pair_2,
                            req_state_pair_1, req_state_pair_0};
   assign stage_valid[0] = req_valid;
   assign req_stall      = !stage_ready[0];
   assign stage_ready[NUM_STAGES] = !rsp_stall;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      sdr_stage #(
         .ROUND (i / QR_WORDS),
         .STEP  (i % QR_WORDS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_state  (stage_state[i]),
         .in_ready  (stage_ready[i]),
         .out_valid (stage_valid[i+1]),
         .out_state (stage_state[i+1]),
         .out_ready (stage_ready[i+1])
      );
   end

   assign res_state        = stage_state[NUM_STAGES];
   assign rsp_valid        = stage_valid[NUM_STAGES];
   assign rsp_mixed_pair_0 = {res_state[1],  res_state[0]};
   assign rsp_mixed_pair_1 = {res_state[3],  res_state[2]};
   assign rsp_mixed_pair_2 = {res_state[5],  res_state[4]};
   assign rsp_mixed_pair_3 = {res_state[7],  res_state[6]};
   assign rsp_mixed_pair_4 = {res_state[9],  res_state[8]};
   assign rsp_mixed_pair_5 = {res_state[11], res_state[10]};
   assign rsp_mixed_pair_6 = {res_state[13], res_state[12]};
   assign rsp_mixed_pair_7 = {res_state[15], res_state[14]};

   a_empty_out_no_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output register empty");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_valid[NUM_STAGES:1] == '1) && rsp_stall)
      else $error("input stalled with a free pipeline stage");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> stage_valid[NUM_STAGES:1] == '0)
      else $error("stage valid bits not cleared by reset");

endmodule

`default_nettype wire

[src/sdr_lane.sv]
// ----------------------------------------------------------------------------
// sdr_lane
// One quarterround step for one lane: add modulo 2^32, rotate left by a
// fixed amount, xor into the target word.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_lane #(
   parameter int unsigned ROT = 7
) (
   input  wire  sdr_pkg::word_type add_a,
   input  wire  sdr_pkg::word_type add_b,
   input  wire  sdr_pkg::word_type xor_in,
   output sdr_pkg::word_type       word_out
);
   import sdr_pkg::*;

   word_type sum;

   assign sum      = add_a + add_b;
   assign word_out = xor_in ^ ((sum << ROT) | (sum >> (WORD_W - ROT)));

endmodule

`default_nettype wire

[src/sdr_stage.sv]
// ----------------------------------------------------------------------------
// sdr_stage
// One pipeline stage: four lanes apply the same quarterround step to their
// word groups, the updated words merge back into the state register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_stage #(
   parameter int unsigned ROUND = 0,
   parameter int unsigned STEP  = 0
) (
   input  wire  clock,
   input  wire  reset,
   input  wire  in_valid,
   input  wire  sdr_pkg::state_type in_state,
   output logic in_ready,
   output logic out_valid,
   output sdr_pkg::state_type out_state,
   input  wire  out_ready
);
   import sdr_pkg::*;

   localparam int unsigned SRC_B = (STEP + QR_WORDS - 1) % QR_WORDS;
   localparam int unsigned DST   = (STEP + 1) % QR_WORDS;

   logic      valid_ff;
   state_type state_ff;
   state_type state_in;
   word_type  lane_out [QR_LANES];

   for (genvar l = 0; l < QR_LANES; l++) begin : g_lane
      sdr_lane #(
         .ROT (QR_ROT[STEP])
      ) u_lane (
         .add_a    (in_state[QR_ORDER[ROUND][l][STEP]]),
         .add_b    (in_state[QR_ORDER[ROUND][l][SRC_B]]),
         .xor_in   (in_state[QR_ORDER[ROUND][l][DST]]),
         .word_out (lane_out[l])
      );
   end

   always_comb begin
      state_in = in_state;
      for (int l = 0; l < QR_LANES; l++) begin
         state_in[QR_ORDER[ROUND][l[1:0]][DST]] = lane_out[l[1:0]];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks salsa_doubleround against a behavioral doubleround (columnround, then
// rowround) computed for every accepted transaction. Runs directed state
// patterns, back-to-back traffic, a long output hold that fills the pipeline,
// and random and edge-word states with random idle bursts on both channels.
// ----------------------------------------------------------------------------

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import sdr_pkg::*;

   // quarterround word indices, one nibble per position, lane-major from bit 0
   localparam logic [63:0] COLUMN_LANES = 64'hB73F_62EA_1D95_C840;
   localparam logic [63:0] ROW_LANES    = 64'hEDCF_98BA_4765_3210;
   localparam logic [1:0][63:0] MIX_LANES = {ROW_LANES, COLUMN_LANES};

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   state_type req_state;
   logic rsp_valid;
   logic rsp_stall;
   wire [NUM_WORDS*WORD_W-1:0] rsp_flat;

   state_type pending_mixes [$];
   int unsigned accepted_states;
   int unsigned checked_mixes;
   int unsigned input_stall_cycles;
   int unsigned mismatch_count;
   bit sender_gaps;
   bit receiver_gaps;
   bit hold_output;
   int unsigned hold_cycles;

   salsa_doubleround dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_state_pair_0 (req_state[1:0]),
      .req_state_pair_1 (req_state[3:2]),
      .req_state_pair_2 (req_state[5:4]),
      .req_state_pair_3 (req_state[7:6]),
      .req_state_pair_4 (req_state[9:8]),
      .req_state_pair_5 (req_state[11:10]),
      .req_state_pair_6 (req_state[13:12]),
      .req_state_pair_7 (req_state[15:14]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mixed_pair_0 (rsp_flat[0*64 +: 64]),
      .rsp_mixed_pair_1 (rsp_flat[1*64 +: 64]),
      .rsp_mixed_pair_2 (rsp_flat[2*64 +: 64]),
      .rsp_mixed_pair_3 (rsp_flat[3*64 +: 64]),
      .rsp_mixed_pair_4 (rsp_flat[4*64 +: 64]),
      .rsp_mixed_pair_5 (rsp_flat[5*64 +: 64]),
      .rsp_mixed_pair_6 (rsp_flat[6*64 +: 64]),
      .rsp_mixed_pair_7 (rsp_flat[7*64 +: 64])
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic word_type word_rotl(word_type v, int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic state_type mix_state(state_type s);
      state_type w;
      word_type y0, y1, y2, y3;
      logic [3:0] i0, i1, i2, i3;
      w = s;
      for (int r = 0; r < 2; r++) begin
         for (int l = 0; l < 4; l++) begin
            i0 = MIX_LANES[r][(l*4+0)*4 +: 4];
            i1 = MIX_LANES[r][(l*4+1)*4 +: 4];
            i2 = MIX_LANES[r][(l*4+2)*4 +: 4];
            i3 = MIX_LANES[r][(l*4+3)*4 +: 4];
            y0 = w[i0];
            y1 = w[i1];
            y2 = w[i2];
            y3 = w[i3];
            y1 = y1 ^ word_rotl(y0 + y3, 7);
            y2 = y2 ^ word_rotl(y1 + y0, 9);
            y3 = y3 ^ word_rotl(y2 + y1, 13);
            y0 = y0 ^ word_rotl(y3 + y2, 18);
            w[i0] = y0;
            w[i1] = y1;
            w[i2] = y2;
            w[i3] = y3;
         end
      end
      return w;
   endfunction

   task automatic send_state(state_type s);
      int unsigned gap;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_state <= s;
      do @(posedge clock); while (req_stall);
      pending_mixes.push_back(mix_state(s));
      accepted_states++;
   endtask

   function automatic state_type random_state();
      state_type s;
      for (int k = 0; k < NUM_WORDS; k++) s[k] = $urandom;
      return s;
   endfunction

   // receiver side: random stall bursts, or one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_output = 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) input_stall_cycles++;
   end

   always @(posedge clock) begin
      state_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_mixes.size() == 0) begin
            $error("unexpected transaction on rsp channel");
            mismatch_count++;
         end else begin
            want = pending_mixes.pop_front();
            checked_mixes++;
            for (int k = 0; k < 8; k++) begin
               if (rsp_flat[k*64 +: 64] !== {want[2*k+1], want[2*k]}) begin
                  $error("mixed_pair_%0d: expected %h, actual %h", k,
                         {want[2*k+1], want[2*k]}, rsp_flat[k*64 +: 64]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic test_directed();
      state_type s;
      send_state('0);
      send_state('1);
      s = '0;
      s[0] = 32'h0000_0001;
      send_state(s);
      s[0] = 32'h8000_0000;
      send_state(s);
      for (int k = 0; k < NUM_WORDS; k++) s[k] = k[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
      send_state(s);
      send_state(~s);
      for (int k = 0; k < NUM_WORDS; k++) s[k] = k;
      send_state(s);
      send_state(~s);
      // the sigma constant on the diagonal
      s = '0;
      s[0]  = 32'h6170_7865;
      s[5]  = 32'h3320_646e;
      s[10] = 32'h7962_2d32;
      s[15] = 32'h6b20_6574;
      send_state(s);
      for (int k = 0; k < 12; k++) begin
         s = '0;
         s[k] = 32'h1 << (k*2 + 7);
         s[15-k] = 32'hFFFF_FFFF;
         send_state(s);
      end
   endtask

   task automatic test_back_to_back(int unsigned count);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      repeat (count) send_state(random_state());
   endtask

   task automatic test_output_hold();
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      hold_cycles = 300;
      hold_output = 1'b1;
      repeat (40) send_state(random_state());
   endtask

   task automatic test_random_idling(int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         // every 100 states, pick at random whether each channel idles
         if (n % 100 == 0) begin
            sender_gaps = $urandom_range(0, 2) != 0;
            receiver_gaps = $urandom_range(0, 2) != 0;
         end
         send_state(random_state());
      end
   endtask

   task automatic test_edge_words(int unsigned count);
      state_type s;
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      repeat (count) begin
         for (int k = 0; k < NUM_WORDS; k++) begin
            case ($urandom_range(0, 4))
               0: s[k] = 32'h0000_0000;
               1: s[k] = 32'hFFFF_FFFF;
               2: s[k] = 32'h8000_0000;
               3: s[k] = 32'h7FFF_FFFF;
               default: s[k] = $urandom;
            endcase
         end
         send_state(s);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_state = '0;
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      hold_output = 1'b0;
      hold_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_back_to_back(300);
      test_output_hold();
      test_random_idling(1000);
      test_edge_words(200);
      test_back_to_back(100);
      req_valid <= 1'b0;
      while (pending_mixes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d transactions: directed patterns, back-to-back, edge words",
               accepted_states);
      $display("input stalled for %0d cycles incl. a long output hold, %0d results checked",
               input_stall_cycles, checked_mixes);
      if (mismatch_count == 0 && pending_mixes.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench failed");
      $finish;
   end

endmodule

[sim.f]
src/sdr_pkg.sv
src/sdr_lane.sv
src/sdr_stage.sv
src/salsa_doubleround.sv
verif/testbench.sv
